### sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the interval set table.
// ----------------------------------------------------------------------------
`default_nettype none
package ist_pkg;

  localparam int DEF_MAX_INTERVALS = 16;
  localparam int BOUND_W = 64;
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_INCLUDES = 3'd2,
    CMD_READ     = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDCAP,
    S_SCAN_RD,
    S_PROC,
    S_EXTRA,
    S_FINAL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_SCAN,
    K_READ,
    K_NONE
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_idx;
    logic rd_cap;
    logic proc;
    logic extra;
    logic fin;
    logic finish;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  scan_end;
    logic  last_entry;
    logic  need_extra;
    logic  out_busy;
  } sts_t;

endpackage
`default_nettype wire

### sv/ist_ram.sv
// ----------------------------------------------------------------------------
// ist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ist_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                      wdata,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/ist_ctrl.sv
// ----------------------------------------------------------------------------
// ist_ctrl
// Command sequencer: decode, table scan, commit and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module ist_ctrl (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire ist_pkg::sts_t sts,
  output ist_pkg::ctl_t ctl
);
  import ist_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.rd_idx = 1'b1;
        priority case (sts.kind)
          K_READ:  state_next = S_RDCAP;
          K_SCAN:  state_next = sts.scan_end ? S_FINAL : S_SCAN_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_RDCAP: begin
        ctl.rd_cap = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN_RD: begin
        state_next = S_PROC;
      end
      S_PROC: begin
        ctl.proc = 1'b1;
        if (sts.need_extra) begin
          state_next = S_EXTRA;
        end else if (sts.last_entry) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_EXTRA: begin
        ctl.extra = 1'b1;
        state_next = sts.scan_end ? S_FINAL : S_SCAN_RD;
      end
      S_FINAL: begin
        ctl.fin = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### sv/ist_dp.sv
// ----------------------------------------------------------------------------
// ist_dp
// Datapath: ping-pong table banks, merge/split logic, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ist_dp #(
  parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire [ist_pkg::CMD_W-1:0]          in_cmd,
  input  wire [ist_pkg::BOUND_W-1:0]        in_low,
  input  wire [ist_pkg::BOUND_W-1:0]        in_high,
  input  wire [ist_pkg::IDX_W-1:0]          in_idx,
  input  wire ist_pkg::ctl_t                ctl,
  output ist_pkg::sts_t                     sts,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [ist_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import ist_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int RW = 2 * BOUND_W;

  logic [CMD_W-1:0]          cmd;
  logic signed [BOUND_W-1:0] lo, hi, mlo, mhi, plo, phi, elo, ehi;
  logic [IDX_W-1:0]          idx;
  logic [CW-1:0]             count, n, i;
  logic                      bank, placed, fail, hit, evalid;

  logic signed [BOUND_W-1:0] mlo_next, mhi_next, plo_next, phi_next, wlo, whi, sl, sh;
  logic [CW-1:0]             n_next;
  logic                      placed_next, fail_next, hit_next, push, we, need_extra;
  logic [RW-1:0]             rd0, rd1, rdat;
  logic [AW-1:0]             raddr;
  logic                      bad, below, above;
  logic [BOUND_W-1:0]        gap_lo, gap_hi;

  assign bad = (cmd == CMD_ADD || cmd == CMD_REMOVE || cmd == CMD_INCLUDES) &&
               ($signed(lo) > $signed(hi));

  assign raddr = ctl.rd_idx ? AW'(idx) : AW'(i);
  assign rdat  = bank ? rd1 : rd0;
  assign sl    = rdat[BOUND_W-1:0];
  assign sh    = rdat[RW-1:BOUND_W];

  // writes always go to the inactive bank; commit flips the bank
  ist_ram #(.WIDTH(RW), .DEPTH(MAX_INTERVALS)) u_bank0 (
    .clk(clk), .we(we && bank), .waddr(AW'(n)), .wdata({whi, wlo}),
    .raddr(raddr), .rdata(rd0)
  );
  ist_ram #(.WIDTH(RW), .DEPTH(MAX_INTERVALS)) u_bank1 (
    .clk(clk), .we(we && !bank), .waddr(AW'(n)), .wdata({whi, wlo}),
    .raddr(raddr), .rdata(rd1)
  );

  // touching test without wrap: difference taken unsigned
  assign gap_lo = BOUND_W'(lo) - BOUND_W'(sh);
  assign gap_hi = BOUND_W'(sl) - BOUND_W'(hi);
  assign below  = (sh < lo) && (gap_lo > BOUND_W'(1));
  assign above  = (sl > hi) && (gap_hi > BOUND_W'(1));

  always_comb begin
    mlo_next = mlo;
    mhi_next = mhi;
    plo_next = plo;
    phi_next = phi;
    placed_next = placed;
    hit_next = hit;
    need_extra = 1'b0;
    push = 1'b0;
    wlo = sl;
    whi = sh;
    if (ctl.proc) begin
      priority case (cmd)
        CMD_ADD: begin
          if (!below && !above) begin
            if (sl < mlo) mlo_next = sl;
            if (sh > mhi) mhi_next = sh;
          end else if (above && !placed) begin
            push = 1'b1;
            wlo = mlo;
            whi = mhi;
            placed_next = 1'b1;
            plo_next = sl;
            phi_next = sh;
            need_extra = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (sh < lo || sl > hi) begin
            push = 1'b1;
          end else if (sl < lo) begin
            push = 1'b1;
            whi = lo - BOUND_W'(1);
            plo_next = hi + BOUND_W'(1);
            phi_next = sh;
            need_extra = sh > hi;
          end else if (sh > hi) begin
            push = 1'b1;
            wlo = hi + BOUND_W'(1);
          end
        end
        CMD_INCLUDES: begin
          if (sl <= lo && sh >= hi) hit_next = 1'b1;
        end
        default: ;
      endcase
    end else if (ctl.extra) begin
      push = 1'b1;
      wlo = plo;
      whi = phi;
    end else if (ctl.fin && cmd == CMD_ADD && !placed) begin
      push = 1'b1;
      wlo = mlo;
      whi = mhi;
    end
    fail_next = fail;
    n_next = n;
    we = 1'b0;
    if (push) begin
      if (n >= CW'(MAX_INTERVALS)) begin
        fail_next = 1'b1;
      end else begin
        we = 1'b1;
        n_next = n + CW'(1);
      end
    end
  end

  always_comb begin
    sts.kind = K_NONE;
    if (!bad) begin
      priority case (cmd)
        CMD_ADD, CMD_REMOVE, CMD_INCLUDES: sts.kind = K_SCAN;
        CMD_READ: sts.kind = K_READ;
        default:  sts.kind = K_NONE;
      endcase
    end
    sts.scan_end   = (i == count);
    sts.last_entry = ((i + CW'(1)) == count);
    sts.need_extra = need_extra;
    sts.out_busy   = m_tvalid && !m_tready;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      lo <= in_low;
      hi <= in_high;
      idx <= in_idx;
      mlo <= in_low;
      mhi <= in_high;
      i <= '0;
      n <= '0;
      placed <= 1'b0;
      fail <= 1'b0;
      hit <= 1'b0;
      evalid <= 1'b0;
      elo <= '0;
      ehi <= '0;
    end else begin
      mlo <= mlo_next;
      mhi <= mhi_next;
      plo <= plo_next;
      phi <= phi_next;
      placed <= placed_next;
      hit <= hit_next;
      n <= n_next;
      fail <= fail_next;
      if (ctl.proc) i <= i + CW'(1);
      if (ctl.rd_cap && ((CW + IDX_W)'(idx) < (CW + IDX_W)'(count))) begin
        evalid <= 1'b1;
        elo <= sl;
        ehi <= sh;
      end
    end
  end

  // table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bank <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctl.fin && (cmd == CMD_ADD || cmd == CMD_REMOVE) && !fail_next) begin
        count <= n_next;
        bank <= !bank;
      end
      if (ctl.finish && cmd == CMD_CLEAR) count <= '0;
    end
  end

  status_t st;
  always_comb begin
    st = ST_OK;
    if (bad) begin
      st = ST_INVALID;
    end else if (fail && (cmd == CMD_ADD || cmd == CMD_REMOVE)) begin
      st = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      m_tdata <= {7'd0,
                  (cmd == CMD_CLEAR) ? CNT_W'(0) : CNT_W'(count),
                  ehi, elo, evalid,
                  hit && (cmd == CMD_INCLUDES) && !bad,
                  st};
    end
  end
endmodule
`default_nettype wire

### sv/interval_set_table.sv
// ----------------------------------------------------------------------------
// interval_set_table
// Sorted table of disjoint signed 64-bit closed intervals with add, remove,
// includes, read and clear commands.
// ----------------------------------------------------------------------------
// channel  dir  signals                  payload
// s_*      in   tvalid tready tdata tuser  command, range, slot
// m_*      out  tvalid tready tdata        status, hit, entry, count
//
// One item at a time. Read decodes, captures the slot and finishes; clear
// and invalid items decode and finish. Add, remove and includes scan the
// active bank, reading then processing each stored entry, with an extra
// write per split or insert, then a final step. The scan writes the other RAM
// bank; commit is a bank flip. Reset empties the table at once. A stalled result
// holds the sequencer, and so the next item, until the result register frees up.
`default_nettype none
module interval_set_table #(
  parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // range_low[63:0], range_high[127:64], entry_index[131:128]
  input  wire [ist_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd[2:0]
  input  wire [ist_pkg::CMD_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // status[1:0], hit[2], entry_valid[3], entry_low[67:4],
  // entry_high[131:68], interval_count[136:132]
  output logic [ist_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import ist_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ist_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .sts(sts), .ctl(ctl)
  );

  ist_dp #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
    .clk(clk), .rst(rst),
    .in_cmd(s_tuser),
    .in_low(s_tdata[63:0]),
    .in_high(s_tdata[127:64]),
    .in_idx(s_tdata[131:128]),
    .ctl(ctl), .sts(sts),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );
endmodule
`default_nettype wire

### dv/interval_set_table_chk.sv
// ----------------------------------------------------------------------------
// interval_set_table_chk
// Watches both streams, keeps a shadow copy of the interval table, and
// compares every result item field by field with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_set_table_chk #(
  parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  input  wire                             s_tready,
  input  wire [ist_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire [ist_pkg::CMD_W-1:0]        s_tuser,
  input  wire                             m_tvalid,
  input  wire                             m_tready,
  input  wire [ist_pkg::OUT_DATA_W-1:0]   m_tdata,
  output int                              fail_count,
  output int                              pending
);
  import ist_pkg::*;

  // packed from the top bit down, so status ends up in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]   interval_count;
    logic [BOUND_W-1:0] entry_high;
    logic [BOUND_W-1:0] entry_low;
    logic               entry_valid;
    logic               hit;
    logic [STAT_W-1:0]  status;
  } table_result_t;

  logic signed [BOUND_W-1:0] tbl_lo [MAX_INTERVALS];
  logic signed [BOUND_W-1:0] tbl_hi [MAX_INTERVALS];
  int                        tbl_n;
  logic signed [BOUND_W-1:0] nxt_lo [MAX_INTERVALS];
  logic signed [BOUND_W-1:0] nxt_hi [MAX_INTERVALS];
  int                        nxt_n;
  table_result_t             expected_results[$];

  function automatic bit push_next(logic signed [BOUND_W-1:0] lo,
                                   logic signed [BOUND_W-1:0] hi);
    if (nxt_n >= MAX_INTERVALS) return 0;
    nxt_lo[nxt_n] = lo;
    nxt_hi[nxt_n] = hi;
    nxt_n++;
    return 1;
  endfunction

  // unsigned difference above one means at least one value lies between
  function automatic bit apart(logic signed [BOUND_W-1:0] a,
                               logic signed [BOUND_W-1:0] b);
    logic [BOUND_W-1:0] d;
    d = $unsigned(b) - $unsigned(a);
    return d > 1;
  endfunction

  function automatic logic [STAT_W-1:0] union_in(logic signed [BOUND_W-1:0] lo,
                                                 logic signed [BOUND_W-1:0] hi);
    logic signed [BOUND_W-1:0] mlo, mhi;
    bit placed, below, above;
    mlo = lo;
    mhi = hi;
    placed = 0;
    nxt_n = 0;
    for (int i = 0; i < tbl_n; i++) begin
      below = tbl_hi[i] < lo && apart(tbl_hi[i], lo);
      above = tbl_lo[i] > hi && apart(hi, tbl_lo[i]);
      if (!below && !above) begin
        if (tbl_lo[i] < mlo) mlo = tbl_lo[i];
        if (tbl_hi[i] > mhi) mhi = tbl_hi[i];
      end else begin
        if (above && !placed) begin
          if (!push_next(mlo, mhi)) return ST_FULL;
          placed = 1;
        end
        if (!push_next(tbl_lo[i], tbl_hi[i])) return ST_FULL;
      end
    end
    if (!placed && !push_next(mlo, mhi)) return ST_FULL;
    tbl_lo = nxt_lo;
    tbl_hi = nxt_hi;
    tbl_n = nxt_n;
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] subtract(logic signed [BOUND_W-1:0] lo,
                                                 logic signed [BOUND_W-1:0] hi);
    nxt_n = 0;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_hi[i] < lo || tbl_lo[i] > hi) begin
        if (!push_next(tbl_lo[i], tbl_hi[i])) return ST_FULL;
      end else begin
        if (tbl_lo[i] < lo && !push_next(tbl_lo[i], lo - 1)) return ST_FULL;
        if (tbl_hi[i] > hi && !push_next(hi + 1, tbl_hi[i])) return ST_FULL;
      end
    end
    tbl_lo = nxt_lo;
    tbl_hi = nxt_hi;
    tbl_n = nxt_n;
    return ST_OK;
  endfunction

  function automatic table_result_t predict_result(logic [CMD_W-1:0] cmd,
                                                   logic [IN_DATA_W-1:0] d);
    table_result_t r;
    logic signed [BOUND_W-1:0] lo, hi;
    int idx;
    r = '0;
    lo = d[63:0];
    hi = d[127:64];
    idx = int'(d[131:128]);
    if (cmd <= CMD_INCLUDES && lo > hi) begin
      r.status = ST_INVALID;
    end else begin
      case (cmd)
        CMD_ADD:    r.status = union_in(lo, hi);
        CMD_REMOVE: r.status = subtract(lo, hi);
        CMD_INCLUDES: begin
          for (int i = 0; i < tbl_n; i++)
            if (tbl_lo[i] <= lo && tbl_hi[i] >= hi) r.hit = 1;
        end
        CMD_READ: begin
          if (idx < tbl_n) begin
            r.entry_valid = 1;
            r.entry_low = tbl_lo[idx];
            r.entry_high = tbl_hi[idx];
          end
        end
        CMD_CLEAR: tbl_n = 0;
        default: ;
      endcase
    end
    r.interval_count = tbl_n[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t got, want;
    if (rst) begin
      tbl_n = 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_results = {expected_results, predict_result(s_tuser, s_tdata)};
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(table_result_t)-1:0];
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.status != want.status)
            $error("status: expected %0d got %0d", want.status, got.status);
          if (got.hit != want.hit)
            $error("hit: expected %0d got %0d", want.hit, got.hit);
          if (got.entry_valid != want.entry_valid)
            $error("entry_valid: expected %0d got %0d", want.entry_valid,
                   got.entry_valid);
          if (got.entry_low != want.entry_low)
            $error("entry_low: expected %h got %h", want.entry_low, got.entry_low);
          if (got.entry_high != want.entry_high)
            $error("entry_high: expected %h got %h", want.entry_high,
                   got.entry_high);
          if (got.interval_count != want.interval_count)
            $error("interval_count: expected %0d got %0d", want.interval_count,
                   got.interval_count);
        end
      end
    end
  end

  assign pending = expected_results.size();

endmodule
`default_nettype wire

### dv/interval_set_table_tb.sv
// ----------------------------------------------------------------------------
// interval_set_table_tb
// Drives directed and random add/remove/includes/read/clear commands into
// the interval table under varying backpressure; a checker judges results.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_set_table_tb;
  import ist_pkg::*;

  localparam logic signed [BOUND_W-1:0] VMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic signed [BOUND_W-1:0] VMIN = 64'h8000_0000_0000_0000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    cmds_sent;

  interval_set_table DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  interval_set_table_chk chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL interval_set_table");
    $finish;
  end

  // receiver stalls at random per phase
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic signed [BOUND_W-1:0] lo,
                          logic signed [BOUND_W-1:0] hi, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid = 1;
    s_tuser = cmd;
    s_tdata = {4'd0, idx, hi, lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 0;
    cmds_sent++;
  endtask

  // mostly small bounds in a narrow window so intervals collide and merge
  function automatic logic signed [BOUND_W-1:0] pick_bound();
    case ($urandom_range(9))
      0: return VMAX - $urandom_range(3);
      1: return VMIN + $urandom_range(3);
      2: return {$urandom, $urandom};
      default: return $signed(64'($urandom_range(120))) - 60;
    endcase
  endfunction

  task automatic random_cmd();
    logic signed [BOUND_W-1:0] a, b, w;
    int r;
    a = pick_bound();
    b = (a >= VMAX - 8) ? VMAX : a + $urandom_range(8);
    if ($urandom_range(19) == 0) begin w = a; a = b; b = w; end
    if ($urandom_range(14) == 0) b = pick_bound();
    r = $urandom_range(99);
    if (r < 40) send_cmd(CMD_ADD, a, b, 4'($urandom));
    else if (r < 60) send_cmd(CMD_REMOVE, a, b, 4'($urandom));
    else if (r < 75) send_cmd(CMD_INCLUDES, a, b, 4'($urandom));
    else if (r < 95) send_cmd(CMD_READ, {$urandom, $urandom}, {$urandom, $urandom},
                              4'($urandom));
    else if (r < 98) send_cmd(CMD_CLEAR, 0, 0, 0);
    else send_cmd(3'($urandom_range(5, 7)), a, b, 4'($urandom));
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int idle_set [4] = '{0, 67, 0, 37};
    int stall_set [4] = '{0, 0, 67, 37};
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = CMD_CLEAR;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cmds_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, adjacency without wrap, invalid, full, split
    send_cmd(CMD_READ, 0, 0, 0);
    send_cmd(CMD_ADD, 5, 4, 0);
    send_cmd(CMD_REMOVE, 1, -1, 0);
    send_cmd(CMD_INCLUDES, VMAX, VMIN, 0);
    send_cmd(CMD_ADD, VMAX, VMAX, 0);
    send_cmd(CMD_ADD, VMIN, VMIN, 0);
    send_cmd(CMD_ADD, VMAX - 1, VMAX - 1, 0);
    send_cmd(CMD_ADD, VMIN + 2, VMIN + 2, 0);
    send_cmd(CMD_INCLUDES, VMAX - 1, VMAX, 0);
    send_cmd(CMD_READ, 0, 0, 4'hf);
    send_cmd(CMD_READ, 0, 0, 2);
    send_cmd(CMD_ADD, VMIN, VMAX, 0);
    send_cmd(CMD_REMOVE, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 1);
    send_cmd(CMD_REMOVE, VMIN, VMAX, 0);
    for (int i = 0; i < 16; i++) send_cmd(CMD_ADD, 64'(4 * i), 64'(4 * i + 1), 0);
    send_cmd(CMD_ADD, 100, 100, 0);
    send_cmd(CMD_REMOVE, 8, 8, 0);
    send_cmd(CMD_READ, 0, 0, 15);
    send_cmd(3'd7, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      send_idle_pct = idle_set[p % 4];
      recv_stall_pct = stall_set[p % 4];
      for (int k = 0; k < 66; k++) random_cmd();
      drain();
    end
    repeat (100) @(negedge clk);

    $display("Sent %0d commands over four idle/stall mixes, incl. bound extremes,",
             cmds_sent);
    $display("merges, splits, table overflow, invalid ranges and slot reads.");
    if (fail_count == 0)
      $display("PASS interval_set_table");
    else
      $display("FAIL interval_set_table");
    $finish;
  end

endmodule
`default_nettype wire

### interval_set_table.f
sv/ist_pkg.sv
sv/ist_ram.sv
sv/ist_ctrl.sv
sv/ist_dp.sv
sv/interval_set_table.sv
dv/interval_set_table_chk.sv
dv/interval_set_table_tb.sv
